// ===== rtl/neo_hookean_stress_energy_unit_defines.svh =====
// Assertion helpers used by the top-level RTL file
`ifndef NEO_HOOKEAN_STRESS_ENERGY_UNIT_DEFINES_SVH
`define NEO_HOOKEAN_STRESS_ENERGY_UNIT_DEFINES_SVH

// same-cycle implication
`define NHS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define NHS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/nhs_pkg.sv =====
`timescale 1ns / 1ps
package nhs_pkg;

  typedef struct packed {
    logic signed [31:0] f_r0c0;
    logic signed [31:0] f_r1c0;
    logic signed [31:0] f_r2c0;
    logic signed [31:0] f_r0c1;
    logic signed [31:0] f_r1c1;
    logic signed [31:0] f_r2c1;
    logic signed [31:0] f_r0c2;
    logic signed [31:0] f_r1c2;
    logic signed [31:0] f_r2c2;
  } nhs_in_t;

  typedef struct packed {
    logic signed [63:0] p_r0c0;
    logic signed [63:0] p_r1c0;
    logic signed [63:0] p_r2c0;
    logic signed [63:0] p_r0c1;
    logic signed [63:0] p_r1c1;
    logic signed [63:0] p_r2c1;
    logic signed [63:0] p_r0c2;
    logic signed [63:0] p_r1c2;
    logic signed [63:0] p_r2c2;
    logic signed [63:0] strain_energy;
  } nhs_out_t;

  // load enables of the two stages inside the lanes and the energy path
  typedef struct packed {
    logic ld_a;
    logic ld_b;
  } nhs_adv_t;

  localparam logic [1:0] REG_SHEAR  = 2'd0;
  localparam logic [1:0] REG_LAMBDA = 2'd1;
  localparam logic [1:0] REG_RATIO  = 2'd2;

  localparam logic [30:0] SHEAR_RST  = 31'd65536;
  localparam logic [30:0] LAMBDA_RST = 31'd131072;
  localparam logic [30:0] RATIO_RST  = 31'd536870912;

  function automatic logic signed [63:0] sat64(input logic signed [80:0] v);
    logic signed [63:0] res;
    if ((&v[80:63]) || !(|v[80:63])) begin
      res = v[63:0];
    end else if (v[80]) begin
      res = {1'b1, 63'd0};
    end else begin
      res = {1'b0, {63{1'b1}}};
    end
    return res;
  endfunction

endpackage

// ===== rtl/nhs_lane.sv =====
`timescale 1ns / 1ps
module nhs_lane (
  input  logic                clk,
  input  nhs_pkg::nhs_adv_t   adv,
  input  logic signed [63:0]  s,
  input  logic signed [64:0]  cof,
  input  logic signed [31:0]  f,
  input  logic        [30:0]  mu,
  output logic signed [63:0]  p
);

  logic signed [64:0]  pll_r;
  logic signed [65:0]  plh_r;
  logic signed [64:0]  phl_r;
  logic signed [64:0]  phh_r;
  logic signed [63:0]  mf_r;
  logic signed [63:0]  p_r;
  logic signed [130:0] v_c;
  logic signed [130:0] rv_c;

  // split s*cof into 32-bit partial products
  always_ff @(posedge clk) begin
    if (adv.ld_a) begin
      pll_r <= $signed({1'b0, s[31:0]}) * $signed({1'b0, cof[31:0]});
      plh_r <= $signed({1'b0, s[31:0]}) * $signed(cof[64:32]);
      phl_r <= $signed(s[63:32]) * $signed({1'b0, cof[31:0]});
      phh_r <= $signed(s[63:32]) * $signed(cof[64:32]);
      mf_r  <= $signed({1'b0, mu}) * f;
    end
  end

  always_comb begin
    v_c  = pll_r + ((plh_r + phl_r) <<< 32) + (phh_r <<< 64) + (mf_r <<< 44);
    rv_c = v_c + (131'sd1 <<< 55);
  end

  always_ff @(posedge clk) begin
    if (adv.ld_b) begin
      p_r <= nhs_pkg::sat64($signed({{6{rv_c[130]}}, rv_c[130:56]}));
    end
  end

  assign p = p_r;

endmodule

// ===== rtl/nhs_energy.sv =====
`timescale 1ns / 1ps
module nhs_energy (
  input  logic                clk,
  input  nhs_pkg::nhs_adv_t   adv,
  input  logic signed [63:0]  s,
  input  logic signed [57:0]  d42,
  input  logic signed [102:0] t1,
  input  logic        [92:0]  t3,
  output logic signed [63:0]  energy
);

  logic signed [64:0]  qll_r;
  logic signed [58:0]  qlh_r;
  logic signed [64:0]  qhl_r;
  logic signed [57:0]  qhh_r;
  logic signed [102:0] t1_r;
  logic        [92:0]  t3_r;
  logic signed [63:0]  e_r;
  logic signed [123:0] t2_c;
  logic signed [125:0] e_c;
  logic signed [125:0] re_c;

  always_ff @(posedge clk) begin
    if (adv.ld_a) begin
      qll_r <= $signed({1'b0, s[31:0]}) * $signed({1'b0, d42[31:0]});
      qlh_r <= $signed({1'b0, s[31:0]}) * $signed(d42[57:32]);
      qhl_r <= $signed(s[63:32]) * $signed({1'b0, d42[31:0]});
      qhh_r <= $signed(s[63:32]) * $signed(d42[57:32]);
      t1_r  <= t1;
      t3_r  <= t3;
    end
  end

  // merge: mu*(Ic-3) + s*d - lam*r^2, all in Q.76
  always_comb begin
    t2_c = (qll_r + ((qlh_r + qhl_r) <<< 32) + (qhh_r <<< 64)) <<< 2;
    e_c  = t1_r + t2_c - $signed({33'd0, t3_r});
    re_c = e_c + (126'sd1 <<< 44);
  end

  always_ff @(posedge clk) begin
    if (adv.ld_b) begin
      e_r <= nhs_pkg::sat64($signed(re_c[125:45]));
    end
  end

  assign energy = e_r;

endmodule

// ===== rtl/neo_hookean_stress_energy_unit.sv =====
`timescale 1ns / 1ps
// Stable Neo-Hookean stress and energy unit.
// Input channel in_valid/in_ready/in_data carries one 3x3 deformation gradient
// (Q4.28, column-major) per beat; output channel out_valid/out_ready/out_data
// carries the nine stress entries (Q32.32) and the strain energy (Q33.31), saturated.
// Moduli are set through cfg_we/cfg_addr/cfg_wdata while no beat is in flight;
// derived constants settle through rr_r, t3a_r/t3b_r and t3_r after a write.
// Pipeline: an accepted beat enters stage 0 and shows on out_valid at stage 8.
// Throughput: one matrix per cycle when not stalled; nine stress lanes and the
// energy path run side by side behind a shared cofactor/determinant front end,
// with every multiplier split into 32-bit partial products and registered.
// Stalls: each stage only holds when it and every stage after it are full, so
// bubbles collapse and in_ready drops only when all 9 stages hold data and the
// output beat is not taken.
// Reset (synchronous, rst_n low) empties the pipeline and restores mu = 1.0,
// lam = 2.0, r = 0.5.
`include "neo_hookean_stress_energy_unit_defines.svh"
module neo_hookean_stress_energy_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  nhs_pkg::nhs_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output nhs_pkg::nhs_out_t out_data,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_addr,
  input  logic [30:0]       cfg_wdata
);

  localparam int NSTG = 9;
  // cofactor entry i = f[CA1]*f[CB1] - f[CA2]*f[CB2]
  localparam int CA1 [9] = '{4, 5, 3, 7, 8, 6, 1, 2, 0};
  localparam int CB1 [9] = '{8, 6, 7, 2, 0, 1, 5, 3, 4};
  localparam int CA2 [9] = '{5, 3, 4, 8, 6, 7, 2, 0, 1};
  localparam int CB2 [9] = '{7, 8, 6, 1, 2, 0, 4, 5, 3};

  logic [30:0] shear_r, lambda_r, ratio_r;
  logic [NSTG-1:0] v_r, v_nxt, adv;
  nhs_pkg::nhs_adv_t lane_adv;

  logic signed [31:0]  f_in [9];
  logic signed [31:0]  fp_r [7][9];
  logic signed [63:0]  cpa_r [9];
  logic signed [63:0]  cpb_r [9];
  logic signed [63:0]  sq_r [9];
  logic signed [64:0]  cofp_r [5][9];
  logic signed [67:0]  ic_sum_c;
  logic signed [67:0]  ic_r;
  logic signed [64:0]  jlo_r [3];
  logic signed [64:0]  jhi_r [3];
  logic signed [63:0]  mlo_r;
  logic signed [67:0]  mhi_r;
  logic signed [98:0]  j_c;
  logic signed [99:0]  d_c;
  logic signed [102:0] t1_c;
  logic signed [99:0]  d_r;
  logic signed [102:0] t1p_r [3];
  logic signed [63:0]  lp0_r, lp1_r;
  logic signed [67:0]  lp2_r;
  logic signed [99:0]  d42_c;
  logic signed [57:0]  d42p_r [2];
  logic signed [132:0] ld_c;
  logic signed [132:0] ls_c;
  logic signed [63:0]  s_r;
  logic        [61:0]  rr_r;
  logic        [62:0]  t3a_r;
  logic        [60:0]  t3b_r;
  logic        [92:0]  t3_r;
  logic signed [63:0]  p_w [9];
  logic signed [63:0]  e_w;

  assign f_in[0] = in_data.f_r0c0;
  assign f_in[1] = in_data.f_r1c0;
  assign f_in[2] = in_data.f_r2c0;
  assign f_in[3] = in_data.f_r0c1;
  assign f_in[4] = in_data.f_r1c1;
  assign f_in[5] = in_data.f_r2c1;
  assign f_in[6] = in_data.f_r0c2;
  assign f_in[7] = in_data.f_r1c2;
  assign f_in[8] = in_data.f_r2c2;

  // a stage loads when it is empty or the stage after it moves
  always_comb begin
    adv[NSTG-1] = !v_r[NSTG-1] || out_ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      adv[k] = !v_r[k] || adv[k+1];
    end
    v_nxt = v_r;
    if (adv[0]) begin
      v_nxt[0] = in_valid;
    end
    for (int k = 1; k < NSTG; k++) begin
      if (adv[k]) begin
        v_nxt[k] = v_r[k-1];
      end
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = v_r[NSTG-1];
  assign lane_adv.ld_a = adv[7];
  assign lane_adv.ld_b = adv[8];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r      <= '0;
      shear_r  <= nhs_pkg::SHEAR_RST;
      lambda_r <= nhs_pkg::LAMBDA_RST;
      ratio_r  <= nhs_pkg::RATIO_RST;
    end else begin
      v_r <= v_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          nhs_pkg::REG_SHEAR:  shear_r  <= cfg_wdata;
          nhs_pkg::REG_LAMBDA: lambda_r <= cfg_wdata;
          nhs_pkg::REG_RATIO:  ratio_r  <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // lam*r^2 follows the registers; stable long before a beat needs it
  always_ff @(posedge clk) begin
    rr_r  <= ratio_r * ratio_r;
    t3a_r <= lambda_r * rr_r[31:0];
    t3b_r <= lambda_r * rr_r[61:32];
    t3_r  <= t3a_r + (93'(t3b_r) << 32);
  end

  always_comb begin
    ic_sum_c = '0;
    for (int i = 0; i < 9; i++) begin
      ic_sum_c = ic_sum_c + sq_r[i];
    end
    j_c = '0;
    for (int k = 0; k < 3; k++) begin
      j_c = j_c + jlo_r[k] + (jhi_r[k] <<< 32);
    end
    d_c   = j_c - (100'sd1 <<< 84) - ($signed({69'd0, ratio_r}) <<< 54);
    t1_c  = (mlo_r + (mhi_r <<< 32)) <<< 4;
    d42_c = d_r + (100'sd1 <<< 41);
    ld_c  = lp0_r + (lp1_r <<< 32) + (lp2_r <<< 64);
    ls_c  = ld_c + (133'sd1 <<< 67);
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      for (int i = 0; i < 9; i++) fp_r[0][i] <= f_in[i];
    end
    for (int k = 1; k < 7; k++) begin
      if (adv[k]) begin
        for (int i = 0; i < 9; i++) fp_r[k][i] <= fp_r[k-1][i];
      end
    end
    // stage 1: cross-product terms and squares
    if (adv[1]) begin
      for (int i = 0; i < 9; i++) begin
        cpa_r[i] <= fp_r[0][CA1[i]] * fp_r[0][CB1[i]];
        cpb_r[i] <= fp_r[0][CA2[i]] * fp_r[0][CB2[i]];
        sq_r[i]  <= fp_r[0][i] * fp_r[0][i];
      end
    end
    // stage 2: cofactors, Ic - 3
    if (adv[2]) begin
      for (int i = 0; i < 9; i++) cofp_r[0][i] <= cpa_r[i] - cpb_r[i];
      ic_r <= ic_sum_c - (68'sd3 <<< 56);
    end
    for (int k = 1; k < 5; k++) begin
      if (adv[k+2]) begin
        for (int i = 0; i < 9; i++) cofp_r[k][i] <= cofp_r[k-1][i];
      end
    end
    // stage 3: determinant and mu*Ic partial products
    if (adv[3]) begin
      for (int k = 0; k < 3; k++) begin
        jlo_r[k] <= fp_r[2][k] * $signed({1'b0, cofp_r[0][k][31:0]});
        jhi_r[k] <= fp_r[2][k] * $signed(cofp_r[0][k][64:32]);
      end
      mlo_r <= $signed({1'b0, shear_r}) * $signed({1'b0, ic_r[31:0]});
      mhi_r <= $signed({1'b0, shear_r}) * $signed(ic_r[67:32]);
    end
    // stage 4: d = J - 1 - r
    if (adv[4]) begin
      d_r      <= d_c;
      t1p_r[0] <= t1_c;
    end
    // stage 5: lam*d partial products
    if (adv[5]) begin
      lp0_r     <= $signed({1'b0, lambda_r}) * $signed({1'b0, d_r[31:0]});
      lp1_r     <= $signed({1'b0, lambda_r}) * $signed({1'b0, d_r[63:32]});
      lp2_r     <= $signed({1'b0, lambda_r}) * $signed(d_r[99:64]);
      d42p_r[0] <= d42_c[99:42];
      t1p_r[1]  <= t1p_r[0];
    end
    // stage 6: s = lam*d in Q.32
    if (adv[6]) begin
      s_r       <= ls_c[131:68];
      d42p_r[1] <= d42p_r[0];
      t1p_r[2]  <= t1p_r[1];
    end
  end

  for (genvar i = 0; i < 9; i++) begin : g_lane
    nhs_lane u_lane (
      .clk (clk),
      .adv (lane_adv),
      .s   (s_r),
      .cof (cofp_r[4][i]),
      .f   (fp_r[6][i]),
      .mu  (shear_r),
      .p   (p_w[i])
    );
  end

  nhs_energy u_energy (
    .clk    (clk),
    .adv    (lane_adv),
    .s      (s_r),
    .d42    (d42p_r[1]),
    .t1     (t1p_r[2]),
    .t3     (t3_r),
    .energy (e_w)
  );

  assign out_data.p_r0c0        = p_w[0];
  assign out_data.p_r1c0        = p_w[1];
  assign out_data.p_r2c0        = p_w[2];
  assign out_data.p_r0c1        = p_w[3];
  assign out_data.p_r1c1        = p_w[4];
  assign out_data.p_r2c1        = p_w[5];
  assign out_data.p_r0c2        = p_w[6];
  assign out_data.p_r1c2        = p_w[7];
  assign out_data.p_r2c2        = p_w[8];
  assign out_data.strain_energy = e_w;

  `NHS_ASSERT_IMP(a_stall_full, !in_ready, (v_r == '1) && !out_ready, "input stalled with a bubble")
  `NHS_ASSERT_NXT(a_stage_move, v_r[0] && adv[1], v_r[1], "beat lost between stage 0 and 1")
  `NHS_ASSERT_NXT(a_out_drain, out_valid && out_ready && !v_r[7], !out_valid, "output beat repeated")

endmodule

// ===== test/nhs_checker.sv =====
`timescale 1ns / 1ps
module nhs_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  nhs_pkg::nhs_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  nhs_pkg::nhs_out_t out_data,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_addr,
  input  logic [30:0]       cfg_wdata,
  output int                errors,
  output int                pending
);

  typedef logic signed [127:0] w128_t;

  logic [30:0] mu_q, lam_q, ratio_q;
  nhs_pkg::nhs_out_t stress_energy_q[$];

  // all intermediates wrap at 128 bits, as the golden arithmetic does
  function automatic w128_t rnd(input w128_t a, input int k);
    w128_t t;
    t = a + (128'sd1 <<< (k - 1));
    return t >>> k;
  endfunction

  function automatic logic signed [63:0] clip64(input w128_t a);
    logic signed [63:0] res;
    if (a[127:63] == {65{a[63]}}) begin
      res = a[63:0];
    end else if (a[127]) begin
      res = {1'b1, 63'd0};
    end else begin
      res = {1'b0, {63{1'b1}}};
    end
    return res;
  endfunction

  function automatic nhs_pkg::nhs_out_t stress_energy(input nhs_pkg::nhs_in_t x,
                                                      input logic [30:0] mu_r,
                                                      input logic [30:0] lam_r,
                                                      input logic [30:0] r_r);
    w128_t f[9], cf[9], a[3], b[3];
    w128_t mu, lam, r, j, d, s, ic, d42, e, v;
    logic [639:0] res;
    mu  = $signed({97'd0, mu_r});
    lam = $signed({97'd0, lam_r});
    r   = $signed({97'd0, r_r});
    for (int i = 0; i < 9; i++) f[i] = $signed(x[(8 - i) * 32 +: 32]);
    for (int c = 0; c < 3; c++) begin
      for (int k = 0; k < 3; k++) begin
        a[k] = f[((c + 1) % 3) * 3 + k];
        b[k] = f[((c + 2) % 3) * 3 + k];
      end
      cf[c * 3 + 0] = a[1] * b[2] - a[2] * b[1];
      cf[c * 3 + 1] = a[2] * b[0] - a[0] * b[2];
      cf[c * 3 + 2] = a[0] * b[1] - a[1] * b[0];
    end
    j = f[0] * cf[0] + f[1] * cf[1] + f[2] * cf[2];
    d = j - (128'sd1 <<< 84) - (r <<< 54);
    s = rnd(lam * d, 68);
    for (int i = 0; i < 9; i++) begin
      v = s * cf[i] + ((mu * f[i]) <<< 44);
      res[(9 - i) * 64 +: 64] = clip64(rnd(v, 56));
    end
    ic = 0;
    for (int i = 0; i < 9; i++) ic = ic + f[i] * f[i];
    ic = ic - (128'sd3 <<< 56);
    d42 = rnd(d, 42);
    e = ((mu * ic) <<< 4) + ((s * d42) <<< 2) - lam * (r * r);
    res[63:0] = clip64(rnd(e, 45));
    return nhs_pkg::nhs_out_t'(res);
  endfunction

  assign pending = stress_energy_q.size();

  always @(posedge clk) begin
    nhs_pkg::nhs_out_t exp_beat;
    if (!rst_n) begin
      mu_q <= nhs_pkg::SHEAR_RST;
      lam_q <= nhs_pkg::LAMBDA_RST;
      ratio_q <= nhs_pkg::RATIO_RST;
      stress_energy_q.delete();
      errors <= 0;
    end else begin
      if (in_valid && in_ready)
        stress_energy_q.push_back(stress_energy(in_data, mu_q, lam_q, ratio_q));
      if (out_valid && out_ready) begin
        if (stress_energy_q.size() == 0) begin
          if (errors < 10) $display("%0t: result beat with nothing expected", $realtime);
          errors <= errors + 1;
        end else begin
          exp_beat = stress_energy_q.pop_front();
          for (int i = 0; i < 10; i++) begin
            if (out_data[(9 - i) * 64 +: 64] !== exp_beat[(9 - i) * 64 +: 64]) begin
              if (errors < 10)
                $display("%0t: field %0d mismatch: expected %h got %h", $realtime, i,
                         exp_beat[(9 - i) * 64 +: 64], out_data[(9 - i) * 64 +: 64]);
              errors <= errors + 1;
              break;
            end
          end
        end
      end
      if (cfg_we) begin
        case (cfg_addr)
          nhs_pkg::REG_SHEAR:  mu_q <= cfg_wdata;
          nhs_pkg::REG_LAMBDA: lam_q <= cfg_wdata;
          nhs_pkg::REG_RATIO:  ratio_q <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end
endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
module testbench;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  nhs_pkg::nhs_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  nhs_pkg::nhs_out_t out_data;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_addr = nhs_pkg::REG_SHEAR;
  logic [30:0] cfg_wdata = '0;
  int errors, pending;
  int send_idle = 0, recv_stall = 0;
  int cycles = 0;

  localparam logic signed [31:0] ONE = 32'sh1000_0000;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  neo_hookean_stress_energy_unit i_dut (.*);

  nhs_checker i_chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 600000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_stall);

  // called at a falling edge, returns at a falling edge
  task automatic send_matrix(input nhs_pkg::nhs_in_t m);
    while ($urandom_range(99) < send_idle) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = m;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic drain(input int extra);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  task automatic set_moduli(input logic [30:0] mu, input logic [30:0] lam,
                            input logic [30:0] r);
    drain(12);
    cfg_we = 1'b1;
    cfg_addr = nhs_pkg::REG_SHEAR;  cfg_wdata = mu;  @(negedge clk);
    cfg_addr = nhs_pkg::REG_LAMBDA; cfg_wdata = lam; @(negedge clk);
    cfg_addr = nhs_pkg::REG_RATIO;  cfg_wdata = r;   @(negedge clk);
    // unmapped index must be ignored
    cfg_addr = 2'd3; cfg_wdata = 31'h7FFF_FFFF; @(negedge clk);
    cfg_we = 1'b0;
    repeat (5) @(negedge clk);
  endtask

  function automatic nhs_pkg::nhs_in_t diag(input logic signed [31:0] a,
                                            input logic signed [31:0] b,
                                            input logic signed [31:0] c);
    nhs_pkg::nhs_in_t m;
    m = '0;
    m.f_r0c0 = a;
    m.f_r1c1 = b;
    m.f_r2c2 = c;
    return m;
  endfunction

  // mostly near-identity deformations, with full-range noise mixed in
  function automatic nhs_pkg::nhs_in_t rand_matrix();
    nhs_pkg::nhs_in_t m;
    int kind;
    kind = $urandom_range(9);
    for (int i = 0; i < 9; i++) begin
      if (kind < 6)
        m[(8 - i) * 32 +: 32] = ((i % 4 == 0) ? ONE : 32'sd0)
                                + $signed($urandom_range(32'h0800_0000)) - 32'sh0400_0000;
      else if (kind < 8)
        m[(8 - i) * 32 +: 32] = $signed($urandom()) >>> $urandom_range(3, 0);
      else
        m[(8 - i) * 32 +: 32] = $urandom();
    end
    return m;
  endfunction

  task automatic run_random(input int n, input int idle, input int stall);
    send_idle = idle;
    recv_stall = stall;
    repeat (n) send_matrix(rand_matrix());
  endtask

  initial begin
    nhs_pkg::nhs_in_t m;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    repeat (5) @(negedge clk);

    send_matrix(diag(ONE, ONE, ONE));
    send_matrix('0);
    send_matrix({9{32'sh7FFF_FFFF}});
    send_matrix({9{32'sh8000_0000}});
    send_matrix(diag(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
    send_matrix(diag(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000));
    send_matrix(diag(-ONE, ONE, ONE));
    send_matrix(diag(ONE <<< 1, ONE, ONE >>> 1));
    m = diag(ONE, ONE, ONE);
    m.f_r0c1 = ONE >>> 2;
    m.f_r2c0 = -(ONE >>> 3);
    send_matrix(m);
    send_matrix({32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
                 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
                 32'sh7FFF_FFFF});

    set_moduli(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h4000_0000);
    send_matrix(diag(ONE, ONE, ONE));
    send_matrix(diag(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
    send_matrix({9{32'sh8000_0000}});
    send_matrix('0);
    set_moduli('0, '0, '0);
    send_matrix(diag(ONE, ONE, ONE));
    send_matrix({9{32'sh7FFF_FFFF}});
    // ratio above 1.0 is taken as written
    set_moduli(31'd65536, 31'd32768, 31'h7FFF_FFFF);
    send_matrix(diag(ONE, ONE, ONE));
    send_matrix(diag(32'sh8000_0000, ONE, ONE));

    run_random(250, 0, 0);
    set_moduli(31'($urandom()), 31'($urandom()), 31'($urandom()));
    run_random(200, 77, 0);
    // hold off until the pipeline is empty, then resume
    drain(3);
    set_moduli(31'(32'd65536 + $urandom_range(32'd1 << 20)),
               31'(32'd131072 + $urandom_range(32'd1 << 22)),
               31'($urandom_range(32'h4000_0000)));
    run_random(200, 0, 77);
    set_moduli(31'h7FFF_FFFF, 31'($urandom()), 31'($urandom_range(32'h4000_0000)));
    run_random(200, 13, 13);
    set_moduli(31'd65536, 31'd131072, 31'd536870912);
    run_random(200, $urandom_range(40), $urandom_range(40));

    drain(20);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
